FILE: hw/rtl/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg: shared definitions for the Modbus response frame checker
// Sizes, status codes, register indexes, the data store request and the
// byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int MAX_DATA = 32;
  localparam int DATA_AW  = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int CNT_W    = $clog2(MAX_DATA + 1);
  localparam int POS_W    = 9;
  localparam int BODY_W   = 10;

  localparam logic [POS_W-1:0] POS_MAX  = 9'd511;
  localparam logic [15:0]      CRC_INIT = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY = 16'hA001;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ADDRESS  = 3'd1;
  localparam logic [2:0] ST_FUNCTION = 3'd2;
  localparam logic [2:0] ST_REGISTER = 3'd3;
  localparam logic [2:0] ST_COUNT    = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;
  localparam logic [2:0] ST_CRC      = 3'd6;
  localparam logic [2:0] ST_TOO_LONG = 3'd7;

  localparam logic [2:0] REG_SLAVE_ADDRESS     = 3'd0;
  localparam logic [2:0] REG_READ_MODE         = 3'd1;
  localparam logic [2:0] REG_READ_CODE         = 3'd2;
  localparam logic [2:0] REG_WRITE_CODE        = 3'd3;
  localparam logic [2:0] REG_EXPECTED_REGISTER = 3'd4;
  localparam logic [2:0] REG_EXPECTED_COUNT    = 3'd5;

  typedef struct packed {
    logic               we;
    logic [DATA_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [DATA_AW-1:0] raddr;
  } store_req_t;

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/mrfc_data_store.sv
// ----------------------------------------------------------------------------
// mrfc_data_store: data byte memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mrfc_data_store
  import mrfc_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [MAX_DATA];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

FILE: hw/rtl/modbus_response_frame_checker.sv
// ----------------------------------------------------------------------------
// modbus_response_frame_checker: Modbus-RTU reply checker
// Checks a received reply byte by byte and reports a status item per frame,
// followed by the stored data bytes of a good read reply.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one received byte per item, frame_end
//   set on the final byte of the frame. The CRC update is one byte-wide
//   step per cycle in which a byte is taken.
//   Output channel (out_valid/out_ready): the status item is loaded into the
//   output register at the edge that takes the final byte, so it is offered
//   from the following cycle. After a good read reply, one data item per
//   stored byte follows, one per cycle while out_ready is high, read from
//   the data store (one read port, registered, prefetched). No input is
//   taken during that replay.
//   Configuration port (cfg_valid/cfg_ready): always ready, index selects
//   the register, indexes past the list are dropped. Registers act on the
//   next byte taken.
//   Reset: synchronous, clears the frame state and loads register defaults;
//   the data store is not cleared and needs no sweep.
//   Stall: while out_ready is low the result is held, and in_ready stays low
//   while a result waits in the output register and out_ready is low.
// ----------------------------------------------------------------------------
module modbus_response_frame_checker
  import mrfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [2:0]  frame_status,
  output logic [7:0]  data_length,
  output logic [7:0]  data_value,
  output logic        run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {
    S_RX     = 2'b01,
    S_REPLAY = 2'b10
  } state_t;

  state_t state;

  logic [7:0]  slave_address;
  logic        read_mode;
  logic [7:0]  read_code;
  logic [7:0]  write_code;
  logic [15:0] expected_register;
  logic [15:0] expected_count;

  logic [POS_W-1:0] pos;
  logic [15:0]      crc;
  logic [7:0]       dlen;
  logic [15:0]      rcrc;
  logic [15:0]      acc;
  logic [2:0]       ferr;

  logic [POS_W-1:0] pos_next;
  logic [15:0]      crc_next;
  logic [7:0]       dlen_next;
  logic [15:0]      rcrc_next;
  logic [15:0]      acc_next;
  logic [2:0]       ferr_next;
  logic [2:0]       status_next;
  logic [CNT_W-1:0] n_items;

  logic [CNT_W-1:0] rep_cnt;
  logic [CNT_W-1:0] rep_total;
  logic             rep_last;

  logic       in_acc;
  logic       slot_free;
  logic       out_load;
  store_req_t store_req;
  logic [7:0] store_q;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_RX) && slot_free;
  assign in_acc    = in_valid && in_ready;
  assign rep_last  = (rep_cnt + 1'b1) == rep_total;
  assign out_load  = (state == S_RX) ? (in_acc && frame_end) : slot_free;

  // Per-byte parse, CRC and error recording.
  always_comb begin
    logic [BODY_W-1:0] p;
    logic [BODY_W-1:0] body_pre;
    logic [BODY_W-1:0] body_post;
    logic [BODY_W-1:0] idx;
    logic [2:0]        code;
    p         = BODY_W'(pos);
    body_pre  = read_mode ? (BODY_W'(dlen) + BODY_W'(3)) : BODY_W'(6);
    crc_next  = (p < body_pre) ? crc16_byte(crc, rx_byte) : crc;
    dlen_next = dlen;
    acc_next  = acc;
    code      = ST_OK;
    idx       = p - BODY_W'(3);
    store_req = '0;

    if (p == BODY_W'(0)) begin
      if (rx_byte != slave_address) code = ST_ADDRESS;
    end else if (p == BODY_W'(1)) begin
      if (rx_byte != (read_mode ? read_code : write_code)) code = ST_FUNCTION;
    end else if (read_mode) begin
      if (p == BODY_W'(2)) begin
        dlen_next = rx_byte;
        if (rx_byte > 8'(MAX_DATA)) code = ST_TOO_LONG;
      end else if (p < body_pre) begin
        if (idx < BODY_W'(MAX_DATA)) begin
          store_req.we    = in_acc;
          store_req.waddr = idx[DATA_AW-1:0];
          store_req.wdata = rx_byte;
        end
      end
    end else begin
      if (p == BODY_W'(2) || p == BODY_W'(4)) begin
        acc_next = {rx_byte, 8'h00};
      end else if (p == BODY_W'(3)) begin
        acc_next = acc | {8'h00, rx_byte};
        if (acc_next != expected_register) code = ST_REGISTER;
      end else if (p == BODY_W'(5)) begin
        acc_next = acc | {8'h00, rx_byte};
        if (acc_next != expected_count) code = ST_COUNT;
      end
    end

    ferr_next = (ferr != ST_OK) ? ferr : code;

    body_post = read_mode ? (BODY_W'(dlen_next) + BODY_W'(3)) : BODY_W'(6);
    rcrc_next = rcrc;
    if (p == body_post) begin
      rcrc_next = {rcrc[15:8], rx_byte};
    end else if (p == body_post + BODY_W'(1)) begin
      rcrc_next = {rx_byte, rcrc[7:0]};
    end

    pos_next = (pos < POS_MAX) ? pos + 1'b1 : pos;

    priority if (ferr_next != ST_OK) begin
      status_next = ferr_next;
    end else if (BODY_W'(pos_next) < body_post + BODY_W'(2)) begin
      status_next = ST_SHORT;
    end else if (rcrc_next != crc_next) begin
      status_next = ST_CRC;
    end else begin
      status_next = ST_OK;
    end

    if (status_next == ST_OK && read_mode) begin
      n_items = (dlen_next > 8'(MAX_DATA)) ? CNT_W'(MAX_DATA) : CNT_W'(dlen_next);
    end else begin
      n_items = '0;
    end

    // Prefetch the first stored byte with the status item, then one ahead.
    // Writes happen only while receiving, reads only at or after frame end,
    // and a good frame never ends on a data byte, so the ports never collide.
    if (state == S_RX) begin
      store_req.re    = in_acc && frame_end && (n_items != '0);
      store_req.raddr = '0;
    end else begin
      store_req.re    = slot_free && !rep_last;
      store_req.raddr = DATA_AW'(rep_cnt + 1'b1);
    end
  end

  mrfc_data_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address     <= 8'd1;
      read_mode         <= 1'b1;
      read_code         <= 8'd3;
      write_code        <= 8'd16;
      expected_register <= 16'd0;
      expected_count    <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SLAVE_ADDRESS:     slave_address     <= cfg_data[7:0];
        REG_READ_MODE:         read_mode         <= cfg_data[0];
        REG_READ_CODE:         read_code         <= cfg_data[7:0];
        REG_WRITE_CODE:        write_code        <= cfg_data[7:0];
        REG_EXPECTED_REGISTER: expected_register <= cfg_data;
        REG_EXPECTED_COUNT:    expected_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RX;
      out_valid <= 1'b0;
      pos       <= '0;
      crc       <= CRC_INIT;
      dlen      <= '0;
      rcrc      <= '0;
      acc       <= '0;
      ferr      <= ST_OK;
      rep_cnt   <= '0;
      rep_total <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_RX: begin
          if (in_acc) begin
            if (frame_end) begin
              item_kind    <= 1'b0;
              frame_status <= status_next;
              data_length  <= read_mode ? dlen_next : 8'd0;
              data_value   <= 8'd0;
              run_end      <= (n_items == '0);
              rep_cnt      <= '0;
              rep_total    <= n_items;
              if (n_items != '0) begin
                state <= S_REPLAY;
              end
              // clear per-frame state
              pos  <= '0;
              crc  <= CRC_INIT;
              dlen <= '0;
              rcrc <= '0;
              acc  <= '0;
              ferr <= ST_OK;
            end else begin
              pos  <= pos_next;
              crc  <= crc_next;
              dlen <= dlen_next;
              rcrc <= rcrc_next;
              acc  <= acc_next;
              ferr <= ferr_next;
            end
          end
        end
        S_REPLAY: begin
          if (slot_free) begin
            item_kind    <= 1'b1;
            frame_status <= ST_OK;
            data_value   <= store_q;
            run_end      <= rep_last;
            rep_cnt      <= rep_cnt + 1'b1;
            if (rep_last) begin
              state <= S_RX;
            end
          end
        end
        default: state <= S_RX;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_replay_has_item: assert property (@(posedge clk) disable iff (rst)
    state == S_REPLAY |-> out_valid)
    else $error("replay running with empty output register");

  a_replay_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_REPLAY |-> (rep_cnt < rep_total))
    else $error("replay counter past frame data count");

  a_data_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind |-> (frame_status == ST_OK) && (data_length != 8'd0))
    else $error("data item without a good read reply");

  a_frame_end_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && frame_end |=> out_valid && !item_kind)
    else $error("final byte did not produce a status item");
`endif

endmodule

FILE: tb/mrfc_reply_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrfc_reply_monitor: reply tracker for the Modbus response frame checker
// Watches the byte, result and register channels, keeps its own copy of the
// frame state and registers, queues the status and data items each frame
// should yield and compares every accepted result item against the oldest.
// ----------------------------------------------------------------------------
package mrfc_tb_pkg;

  // Serial form of the reflected CRC-16: one feedback bit per data bit.
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0] value);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ value[k]) begin
        c = {1'b0, c[15:1]} ^ mrfc_pkg::CRC_POLY;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

endpackage

module mrfc_reply_monitor
  import mrfc_pkg::*;
  import mrfc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        item_kind,
  input  logic [2:0]  frame_status,
  input  logic [7:0]  data_length,
  input  logic [7:0]  data_value,
  input  logic        run_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          outstanding_items
);

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] length;
    logic [7:0] value;
    logic       last;
  } reply_item_t;

  reply_item_t expected_replies[$];

  // register copy
  logic [7:0]  slave_addr;
  logic        rd_mode;
  logic [7:0]  rd_code;
  logic [7:0]  wr_code;
  logic [15:0] exp_reg;
  logic [15:0] exp_cnt;

  // per-frame state
  logic [8:0]  pos;
  logic [15:0] run_crc;
  logic [7:0]  decl_len;
  logic [15:0] rx_crc;
  logic [15:0] field_acc;
  logic [2:0]  first_err;
  logic [7:0]  byte_store [MAX_DATA];

  initial mismatch_count = 0;

  function automatic void clear_frame();
    pos       = '0;
    run_crc   = CRC_INIT;
    decl_len  = '0;
    rx_crc    = '0;
    field_acc = '0;
    first_err = ST_OK;
  endfunction

  function automatic void note_error(input logic [2:0] code);
    if (first_err == ST_OK) begin
      first_err = code;
    end
  endfunction

  function automatic void apply_register(input logic [2:0] index, input logic [15:0] value);
    case (index)
      REG_SLAVE_ADDRESS:     slave_addr = value[7:0];
      REG_READ_MODE:         rd_mode    = value[0];
      REG_READ_CODE:         rd_code    = value[7:0];
      REG_WRITE_CODE:        wr_code    = value[7:0];
      REG_EXPECTED_REGISTER: exp_reg    = value;
      REG_EXPECTED_COUNT:    exp_cnt    = value;
      default: ;
    endcase
  endfunction

  // Advance the frame state by one byte; on the final byte queue the status
  // item and, after a good read reply, one item per stored data byte.
  function automatic void absorb_rx_byte(input logic [7:0] value, input logic is_last);
    int          p;
    int          body;
    int          need;
    int          n;
    logic [2:0]  verdict;
    logic [7:0]  dlen;
    reply_item_t r;
    p = pos;
    body = rd_mode ? 3 + int'(decl_len) : 6;
    if (p < body) begin
      run_crc = crc16_modbus_step(run_crc, value);
    end
    if (p == 0) begin
      if (value != slave_addr) note_error(ST_ADDRESS);
    end else if (p == 1) begin
      if (value != (rd_mode ? rd_code : wr_code)) note_error(ST_FUNCTION);
    end else if (rd_mode) begin
      if (p == 2) begin
        decl_len = value;
        if (int'(value) > MAX_DATA) note_error(ST_TOO_LONG);
      end else if (p < body && p - 3 < MAX_DATA) begin
        byte_store[p - 3] = value;
      end
    end else begin
      if (p == 2 || p == 4) begin
        field_acc = {value, 8'h00};
      end else if (p == 3) begin
        field_acc[7:0] = value;
        if (field_acc != exp_reg) note_error(ST_REGISTER);
      end else if (p == 5) begin
        field_acc[7:0] = value;
        if (field_acc != exp_cnt) note_error(ST_COUNT);
      end
    end

    // the byte count just seen moves the CRC field
    if (rd_mode) body = 3 + int'(decl_len);
    if (p == body) begin
      rx_crc[7:0] = value;
    end else if (p == body + 1) begin
      rx_crc[15:8] = value;
    end
    if (pos != POS_MAX) pos = pos + 1'b1;
    if (!is_last) return;

    need = body + 2;
    if (first_err != ST_OK) begin
      verdict = first_err;
    end else if (int'(pos) < need) begin
      verdict = ST_SHORT;
    end else if (rx_crc != run_crc) begin
      verdict = ST_CRC;
    end else begin
      verdict = ST_OK;
    end
    dlen = rd_mode ? decl_len : 8'h00;
    n = (verdict == ST_OK && rd_mode) ? int'(decl_len) : 0;
    if (n > MAX_DATA) n = MAX_DATA;

    r = '{kind: 1'b0, status: verdict, length: dlen, value: 8'h00, last: (n == 0)};
    expected_replies.push_back(r);
    for (int i = 0; i < n; i++) begin
      r = '{kind: 1'b1, status: ST_OK, length: dlen, value: byte_store[i],
            last: (i + 1 == n)};
      expected_replies.push_back(r);
    end
    clear_frame();
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    reply_item_t want;
    if (rst) begin
      slave_addr = 8'd1;
      rd_mode    = 1'b1;
      rd_code    = 8'd3;
      wr_code    = 8'd16;
      exp_reg    = 16'd0;
      exp_cnt    = 16'd0;
      clear_frame();
      for (int i = 0; i < MAX_DATA; i++) byte_store[i] = 8'h00;
      expected_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        absorb_rx_byte(rx_byte, frame_end);
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result item with none expected: kind %0d status %0d value %0d",
                 item_kind, frame_status, data_value);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("item_kind", want.kind, item_kind);
          check_field("frame_status", want.status, frame_status);
          check_field("data_length", want.length, data_length);
          check_field("data_value", want.value, data_value);
          check_field("run_end", want.last, run_end);
        end
      end
    end
    outstanding_items <= expected_replies.size();
  end

endmodule

FILE: tb/modbus_response_frame_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_response_frame_checker_tb: frame checker testbench
// Sends read replies and write acknowledges, clean and damaged (bad fields,
// bad CRC, cut short, trailing bytes, oversize counts, noise), under several
// register settings, with random gaps on the byte side and random stalls on
// the result side. The reply monitor predicts and compares every result.
// ----------------------------------------------------------------------------
module modbus_response_frame_checker_tb;
  import mrfc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_BYTES  = 50;

  // indexes past the register list, dropped by the block
  localparam logic [2:0] REG_NONE_LO = 3'd6;
  localparam logic [2:0] REG_NONE_HI = 3'd7;

  // damage applied to a well-formed frame
  localparam int BAD_ADDR = 1;
  localparam int BAD_FUNC = 2;
  localparam int BAD_REG  = 4;
  localparam int BAD_CNT  = 8;
  localparam int BAD_CRC  = 16;

  typedef enum int {TAIL_EXACT, TAIL_SHORT, TAIL_EXTRA} tail_kind_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic        out_valid;
  logic        out_ready;
  logic        item_kind;
  logic [2:0]  frame_status;
  logic [7:0]  data_length;
  logic [7:0]  data_value;
  logic        run_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatch_count;
  int outstanding_items;
  int cycle_count;
  int sent_bytes;
  int phase_no;
  bit calm_tail;

  // register values as last written, used to shape frames
  logic [7:0]  cur_slave;
  logic        cur_mode;
  logic [7:0]  cur_rcode;
  logic [7:0]  cur_wcode;
  logic [15:0] cur_reg;
  logic [15:0] cur_cnt;

  logic [7:0] frame_bytes[$];

  modbus_response_frame_checker u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .item_kind    (item_kind),
    .frame_status (frame_status),
    .data_length  (data_length),
    .data_value   (data_value),
    .run_end      (run_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mrfc_reply_monitor u_reply_monitor (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .frame_end         (frame_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .item_kind         (item_kind),
    .frame_status      (frame_status),
    .data_length       (data_length),
    .data_value        (data_value),
    .run_end           (run_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .outstanding_items (outstanding_items)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] flip8();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [15:0] flip16();
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [7:0] pick8();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold cfg_valid high after the write; the caller drops it after a batch.
  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    case (index)
      REG_SLAVE_ADDRESS:     cur_slave = value[7:0];
      REG_READ_MODE:         cur_mode  = value[0];
      REG_READ_CODE:         cur_rcode = value[7:0];
      REG_WRITE_CODE:        cur_wcode = value[7:0];
      REG_EXPECTED_REGISTER: cur_reg   = value;
      REG_EXPECTED_COUNT:    cur_cnt   = value;
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic randomize_setup(input logic mode);
    write_reg(REG_SLAVE_ADDRESS, {8'($urandom), pick8()});
    write_reg(REG_READ_MODE, {15'($urandom), mode});
    write_reg(REG_READ_CODE, {8'($urandom), pick8()});
    write_reg(REG_WRITE_CODE, {8'($urandom), pick8()});
    write_reg(REG_EXPECTED_REGISTER, pick16());
    write_reg(REG_EXPECTED_COUNT, pick16());
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] value, input logic is_last);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= value;
    frame_end <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    sent_bytes += frame_bytes.size();
  endtask

  // Build a frame for the current mode, then damage it as asked.
  task automatic build_frame(input int n_data, input int bad, input tail_kind_t tail);
    logic [15:0] crc;
    logic [15:0] field;
    int          keep;
    frame_bytes.delete();
    frame_bytes.push_back(cur_slave ^ (((bad & BAD_ADDR) != 0) ? flip8() : 8'h00));
    if (cur_mode) begin
      frame_bytes.push_back(cur_rcode ^ (((bad & BAD_FUNC) != 0) ? flip8() : 8'h00));
      frame_bytes.push_back(8'(n_data));
      repeat (n_data) frame_bytes.push_back(8'($urandom));
    end else begin
      frame_bytes.push_back(cur_wcode ^ (((bad & BAD_FUNC) != 0) ? flip8() : 8'h00));
      field = cur_reg ^ (((bad & BAD_REG) != 0) ? flip16() : 16'h0000);
      frame_bytes.push_back(field[15:8]);
      frame_bytes.push_back(field[7:0]);
      field = cur_cnt ^ (((bad & BAD_CNT) != 0) ? flip16() : 16'h0000);
      frame_bytes.push_back(field[15:8]);
      frame_bytes.push_back(field[7:0]);
    end
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = crc16_byte(crc, frame_bytes[i]);
    crc = crc ^ (((bad & BAD_CRC) != 0) ? flip16() : 16'h0000);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    case (tail)
      TAIL_SHORT: begin
        keep = $urandom_range(1, (frame_bytes.size() > 13) ? 12 : frame_bytes.size() - 1);
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
      TAIL_EXTRA: begin
        repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic random_frame();
    int         roll;
    int         n_data;
    int         bad;
    tail_kind_t tail;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
    end else begin
      n_data = $urandom_range(0, 6);
      if (roll < 14) begin
        n_data = $urandom_range(MAX_DATA - 2, MAX_DATA);
      end else if (roll < 19) begin
        n_data = $urandom_range(MAX_DATA + 1, MAX_DATA + 8);
      end
      bad = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 31);
      roll = $urandom_range(0, 19);
      tail = (roll < 3) ? TAIL_SHORT : (roll < 6) ? TAIL_EXTRA : TAIL_EXACT;
      // keep oversize reads cheap most of the time
      if (cur_mode && n_data > MAX_DATA && $urandom_range(0, 3) != 0) tail = TAIL_SHORT;
      build_frame(n_data, bad, tail);
    end
    send_frame();
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding_items != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("modbus_response_frame_checker_tb failed");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= 8'h00;
    frame_end <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SLAVE_ADDRESS;
    cfg_data  <= 16'h0000;
    calm_tail  = 1'b0;
    sent_bytes = 0;
    cur_slave  = 8'd1;
    cur_mode   = 1'b1;
    cur_rcode  = 8'd3;
    cur_wcode  = 8'd16;
    cur_reg    = 16'd0;
    cur_cnt    = 16'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // read replies under the reset settings
    build_frame(0, 0, TAIL_EXACT);
    send_frame();
    build_frame(2, BAD_ADDR | BAD_CRC, TAIL_EXACT);
    send_frame();
    build_frame(255, 0, TAIL_SHORT);
    send_frame();
    frame_bytes.delete();
    frame_bytes.push_back(cur_slave);
    send_frame();
    build_frame(MAX_DATA, 0, TAIL_EXACT);
    send_frame();
    build_frame(1, 0, TAIL_EXTRA);
    send_frame();
    finish_phase();

    // write acknowledges with the opposite extremes
    write_reg(REG_SLAVE_ADDRESS, 16'h0000);
    write_reg(REG_READ_MODE, 16'h0000);
    write_reg(REG_READ_CODE, 16'h0000);
    write_reg(REG_WRITE_CODE, 16'h00FF);
    write_reg(REG_EXPECTED_REGISTER, 16'hFFFF);
    write_reg(REG_EXPECTED_COUNT, 16'hFFFF);
    write_reg(REG_NONE_LO, 16'hFFFF);
    write_reg(REG_NONE_HI, 16'h0000);
    cfg_valid <= 1'b0;
    build_frame(0, 0, TAIL_EXACT);
    send_frame();
    build_frame(0, BAD_FUNC | BAD_CNT, TAIL_EXACT);
    send_frame();
    build_frame(0, BAD_REG, TAIL_EXACT);
    send_frame();
    // count field cut after its high byte: left unchecked, frame is short
    build_frame(0, BAD_CNT, TAIL_EXACT);
    while (frame_bytes.size() > 5) void'(frame_bytes.pop_back());
    send_frame();
    // ignored trailing bytes after a good acknowledge
    build_frame(0, 0, TAIL_EXACT);
    repeat (4) frame_bytes.push_back(8'($urandom));
    send_frame();
    finish_phase();

    sent_bytes = 0;
    phase_no = 1;
    while (sent_bytes < RANDOM_BYTES) begin
      randomize_setup(phase_no[0]);
      repeat (3) random_frame();
      finish_phase();
      phase_no++;
    end

    calm_tail = 1'b1;
    randomize_setup(1'($urandom_range(0, 1)));
    repeat (3) random_frame();
    finish_phase();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && outstanding_items == 0) begin
      $display("modbus_response_frame_checker_tb passed");
    end else begin
      $display("modbus_response_frame_checker_tb failed");
    end
    $finish;
  end

endmodule
